>>> rtl/sps_pkg.sv
// Shared constants and types for the segmented prime sieve.
// No dependencies; compiled first.
package sps_pkg;

   localparam int START_W     = 20;
   localparam int COUNT_W     = 7;
   localparam int FLAGS_W     = 64;
   localparam int MAX_VALUE   = 1048576;
   localparam int WINDOW_SIZE = 64;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_SV_READ,
      ST_SV_TEST,
      ST_SV_STRIKE,
      ST_IDLE,
      ST_W_READ,
      ST_W_TEST,
      ST_W_DIV,
      ST_W_FIRST,
      ST_W_STRIKE,
      ST_W_DONE
   } sps_state_type;

endpackage

>>> rtl/sps_if.sv
// Request and response channel interfaces of the prime sieve.
// Depends on sps_pkg for field widths.
interface sps_req_if;
   logic                         valid;
   logic                         ready;
   logic [sps_pkg::START_W-1:0]  window_start;
   logic [sps_pkg::COUNT_W-1:0]  window_count;

   modport source (output valid, output window_start, output window_count, input ready);
   modport sink   (input valid, input window_start, input window_count, output ready);
endinterface

interface sps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sps_pkg::FLAGS_W-1:0]  prime_flags;
   logic                         range_error;

   modport source (output valid, output prime_flags, output range_error, input ready);
   modport sink   (input valid, input prime_flags, input range_error, output ready);
endinterface

>>> rtl/sps_rem_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle.
// Depends on sps_pkg. Divisor must stay stable while busy.
module sps_rem_unit #(
   parameter int DIV_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [sps_pkg::START_W-1:0] dividend,
   input  logic [DIV_W-1:0]            divisor,
   output logic                        busy,
   output logic [DIV_W-1:0]            remainder
);
   import sps_pkg::*;

   localparam int CNT_W = $clog2(START_W + 1);

   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [START_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W:0]     trial;

   always_comb begin
      trial  = {rem_ff, quo_ff[START_W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (go) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(START_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIV_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         quo_in = {quo_ff[START_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

endmodule

>>> rtl/segmented_prime_sieve_unit.sv
// Segmented prime sieve. After reset the base-prime flags are initialised, then the multiples of
// every index up to sqrt(BASE_LIMIT) still flagged prime are struck, starting at its square.
// Per request, base indices are tested while p*p <= last; for each base prime the serial unit
// reduces the window start modulo p and its multiples in the window are struck; one request at a time.
// The serial remainder unit and the flag memory (one write, one read) set the pace.
// Synchronous active-high reset; no requests are taken until sieving is done.
module segmented_prime_sieve_unit #(
   parameter int BASE_LIMIT = 1024
) (
   input  logic     clock,
   input  logic     reset,
   sps_req_if.sink  req_bus,
   sps_rsp_if.source rsp_bus
);
   import sps_pkg::*;

   localparam int AW     = $clog2(BASE_LIMIT);
   localparam int PW     = AW + 1;
   localparam int PPW    = 2 * AW;
   localparam int WK     = AW + 2;
   localparam int LAST_W = START_W + 1;
   localparam int SQ     = BASE_LIMIT * BASE_LIMIT;
   localparam int LIMIT  = (MAX_VALUE < SQ) ? MAX_VALUE : SQ;
   localparam int LIM_W  = ((LAST_W > $clog2(LIMIT + 1)) ? LAST_W : $clog2(LIMIT + 1)) + 1;
   localparam int CMP_W  = ((PPW > LAST_W) ? PPW : LAST_W) + 1;
   localparam int IDX_W  = $clog2(FLAGS_W);

   localparam logic [LIM_W-1:0] LIMIT_VAL   = LIM_W'(LIMIT);
   localparam logic [PW-1:0]    FIRST_PRIME = PW'(2);

   sps_state_type state_ff, state_in;

   logic [PW-1:0]      p_ff, p_in;
   logic [PPW-1:0]     pp_ff, pp_in;
   logic [WK-1:0]      walk_ff, walk_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [LAST_W-1:0]  last_ff, last_in;
   logic               err_ff, err_in;
   logic [FLAGS_W-1:0] marks_ff, marks_in;
   logic [FLAGS_W-1:0] flags_out_ff, flags_out_in;
   logic               err_out_ff, err_out_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               mem [BASE_LIMIT];
   logic               rd_flag_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic               mem_wdata;

   logic               rem_go;
   logic               rem_busy;
   logic [AW-1:0]      rem_val;

   logic [COUNT_W-1:0] cnt_sat, cnt_eff;
   logic [LIM_W-1:0]   span;
   logic               over;
   logic [FLAGS_W-1:0] init_mask;
   logic [PPW-1:0]     pp_next;
   logic [PW-1:0]      p_inc;
   logic [WK-1:0]      walk_step;
   logic [AW-1:0]      offset;
   logic [CMP_W-1:0]   first_q;

   sps_rem_unit #(.DIV_W(AW)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .go        (rem_go),
      .dividend  (start_ff),
      .divisor   (p_ff[AW-1:0]),
      .busy      (rem_busy),
      .remainder (rem_val)
   );

   always_comb begin
      cnt_sat = (req_bus.window_count > COUNT_W'(WINDOW_SIZE)) ?
                COUNT_W'(WINDOW_SIZE) : req_bus.window_count;
      span    = LIM_W'(req_bus.window_start) + LIM_W'(cnt_sat);
      over    = (cnt_sat != '0) && (span > LIMIT_VAL);
      if (!over) begin
         cnt_eff = cnt_sat;
      end else if (LIM_W'(req_bus.window_start) < LIMIT_VAL) begin
         cnt_eff = COUNT_W'(LIMIT_VAL - LIM_W'(req_bus.window_start));
      end else begin
         cnt_eff = '0;
      end
      if (cnt_eff >= COUNT_W'(FLAGS_W)) begin
         init_mask = '1;
      end else begin
         init_mask = ~({FLAGS_W{1'b1}} << cnt_eff);
      end
      if (req_bus.window_start == '0) begin
         init_mask = init_mask & ~FLAGS_W'(3);
      end else if (req_bus.window_start == START_W'(1)) begin
         init_mask = init_mask & ~FLAGS_W'(1);
      end
   end

   assign pp_next   = PPW'(p_ff[AW-1:0]) * PPW'(p_ff[AW-1:0]);
   assign p_inc     = p_ff + PW'(1);
   assign walk_step = walk_ff + WK'(p_ff);
   assign offset    = (rem_val == '0) ? '0 : (p_ff[AW-1:0] - rem_val);
   assign first_q   = CMP_W'(start_ff) + CMP_W'(offset);

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      pp_in        = pp_ff;
      walk_in      = walk_ff;
      start_in     = start_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      marks_in     = marks_ff;
      flags_out_in = flags_out_ff;
      err_out_in   = err_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mem_we       = 1'b0;
      mem_waddr    = walk_ff[AW-1:0];
      mem_wdata    = 1'b0;
      rem_go       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = (walk_ff >= WK'(2));
            walk_in   = walk_ff + WK'(1);
            if (walk_ff == WK'(BASE_LIMIT - 1)) begin
               p_in     = FIRST_PRIME;
               state_in = ST_SV_READ;
            end
         end
         ST_SV_READ: begin
            pp_in    = pp_next;
            state_in = ST_SV_TEST;
         end
         ST_SV_TEST: begin
            if (CMP_W'(pp_ff) >= CMP_W'(BASE_LIMIT)) begin
               state_in = ST_IDLE;
            end else if (rd_flag_ff) begin
               walk_in  = WK'(pp_ff);
               state_in = ST_SV_STRIKE;
            end else begin
               p_in     = p_inc;
               state_in = ST_SV_READ;
            end
         end
         ST_SV_STRIKE: begin
            mem_we = 1'b1;
            if (walk_step >= WK'(BASE_LIMIT)) begin
               p_in     = p_inc;
               state_in = ST_SV_READ;
            end else begin
               walk_in = walk_step;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               start_in = req_bus.window_start;
               cnt_in   = cnt_eff;
               err_in   = over;
               marks_in = (cnt_eff == '0) ? '0 : init_mask;
               last_in  = LAST_W'(req_bus.window_start) + LAST_W'(cnt_eff) - LAST_W'(1);
               p_in     = FIRST_PRIME;
               state_in = (cnt_eff == '0) ? ST_W_DONE : ST_W_READ;
            end
         end
         ST_W_READ: begin
            pp_in    = pp_next;
            state_in = ST_W_TEST;
         end
         ST_W_TEST: begin
            if (CMP_W'(pp_ff) > CMP_W'(last_ff)) begin
               state_in = ST_W_DONE;
            end else if (rd_flag_ff) begin
               rem_go   = 1'b1;
               state_in = ST_W_DIV;
            end else begin
               p_in     = p_inc;
               state_in = (p_inc == PW'(BASE_LIMIT)) ? ST_W_DONE : ST_W_READ;
            end
         end
         ST_W_DIV: begin
            if (!rem_busy) begin
               state_in = ST_W_FIRST;
            end
         end
         ST_W_FIRST: begin
            if (CMP_W'(pp_ff) > first_q) begin
               walk_in = WK'(CMP_W'(pp_ff) - CMP_W'(start_ff));
            end else begin
               walk_in = WK'(offset);
            end
            state_in = ST_W_STRIKE;
         end
         ST_W_STRIKE: begin
            if (walk_ff < WK'(cnt_ff)) begin
               marks_in = marks_ff & ~(FLAGS_W'(1) << walk_ff[IDX_W-1:0]);
               walk_in  = walk_step;
            end else begin
               p_in     = p_inc;
               state_in = (p_inc == PW'(BASE_LIMIT)) ? ST_W_DONE : ST_W_READ;
            end
         end
         ST_W_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               flags_out_in = marks_ff;
               err_out_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         walk_ff      <= '0;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff         <= p_in;
      pp_ff        <= pp_in;
      start_ff     <= start_in;
      cnt_ff       <= cnt_in;
      last_ff      <= last_in;
      err_ff       <= err_in;
      flags_out_ff <= flags_out_in;
      err_out_ff   <= err_out_in;
   end

   // base-prime flag store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_flag_ff <= mem[p_ff[AW-1:0]];
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.prime_flags = flags_out_ff;
   assign rsp_bus.range_error = err_out_ff;

endmodule

>>> rtl/sps_checker.sv
// Port-level checks for segmented_prime_sieve_unit, attached by bind.
// Depends on sps_pkg and the top level.
module sps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sps_pkg::FLAGS_W-1:0] rsp_prime_flags,
   input logic                        rsp_range_error
);
   import sps_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_prime_flags) && $stable(rsp_range_error))
      else $error("stalled response changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests in flight");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("channels active straight after reset");

endmodule

bind segmented_prime_sieve_unit sps_checker u_sps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_prime_flags (rsp_bus.prime_flags),
   .rsp_range_error (rsp_bus.range_error)
);

>>> verif/tb_segmented_prime_sieve_unit.sv
// Self-checking bench for segmented_prime_sieve_unit: directed and random prime windows,
// each checked against a behavioural window sieve held in a small scoreboard class.
// Depends on sps_pkg and the request/response interfaces in sps_if.sv.
module tb_segmented_prime_sieve_unit;
   import sps_pkg::*;

   localparam int BASE_LIMIT = 1024;
   localparam longint unsigned VALUE_LIMIT =
      (longint'(MAX_VALUE) < longint'(BASE_LIMIT) * BASE_LIMIT) ?
      longint'(MAX_VALUE) : longint'(BASE_LIMIT) * BASE_LIMIT;
   localparam int RANDOM_WINDOWS = 1700;
   localparam int HOLD_CYCLES    = 3000;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 7000;
   localparam int IDLE_PERCENT   = 32;
   localparam int NUM_DIRECTED   = 24;

   localparam int unsigned DIR_START [NUM_DIRECTED] = '{
      0, 0, 0, 1, 1, 2, 0, 12345, 100, 500, 961, 1022, 524288, 999983,
      1042440, 1046529, 1048512, 1048513, 1048575, 1048575, 1048575, 1048575,
      1048000, 3};
   localparam int unsigned DIR_COUNT [NUM_DIRECTED] = '{
      1, 2, 64, 1, 64, 1, 0, 0, 127, 65, 64, 4, 64, 10,
      64, 16, 64, 64, 1, 2, 127, 0,
      64, 62};

   typedef struct {
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] count;
      logic [FLAGS_W-1:0] flags;
      logic               range_error;
   } window_result_type;

   class window_prime_checker;
      bit                is_base_prime [BASE_LIMIT];
      window_result_type pending_windows [$];
      int                failure_count;

      function new();
         int n, m;
         for (n = 0; n < BASE_LIMIT; n++)
            is_base_prime[n] = (n >= 2);
         for (n = 2; n * n < BASE_LIMIT; n++)
            if (is_base_prime[n])
               for (m = n * n; m < BASE_LIMIT; m += n)
                  is_base_prime[m] = 1'b0;
         failure_count = 0;
      endfunction

      function int outstanding();
         return pending_windows.size();
      endfunction

      // Predicts the window bitmap for an accepted request.
      function void note_window(logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
         window_result_type w;
         longint unsigned   base, span, last, p, q, hit;
         base          = 64'(start);
         w.start       = start;
         w.count       = count;
         w.flags       = '0;
         w.range_error = 1'b0;
         span = (count > COUNT_W'(WINDOW_SIZE)) ? 64'(WINDOW_SIZE) : 64'(count);
         if (span > 0 && base + span > VALUE_LIMIT) begin
            w.range_error = 1'b1;
            span = (base < VALUE_LIMIT) ? VALUE_LIMIT - base : 0;
         end
         if (span > 0) begin
            w.flags = (span >= 64) ? '1 : (64'd1 << span) - 64'd1;
            if (base == 0)
               w.flags[1:0] = 2'b00;
            else if (base == 1)
               w.flags[0] = 1'b0;
            last = base + span - 1;
            for (p = 2; p < BASE_LIMIT && p * p <= last; p++) begin
               if (!is_base_prime[p])
                  continue;
               q   = ((base + p - 1) / p) * p;
               hit = (p * p > q) ? p * p : q;
               for (; hit <= last; hit += p)
                  w.flags[hit - base] = 1'b0;
            end
         end
         pending_windows = {pending_windows, w};
      endfunction

      function void check_flags(logic [FLAGS_W-1:0] flags, logic range_error);
         window_result_type w;
         if (pending_windows.size() == 0) begin
            failure_count++;
            if (failure_count <= 10)
               $display("unexpected response: flags %h range_error %0b", flags, range_error);
            return;
         end
         w = pending_windows.pop_front();
         if (flags !== w.flags || range_error !== w.range_error) begin
            failure_count++;
            if (failure_count <= 10)
               $display("mismatch start %0d count %0d: expected %h/%0b, got %h/%0b",
                        w.start, w.count, w.flags, w.range_error, flags, range_error);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm_stretch;
   bit   hold_pending;
   int   hold_left;
   int   quiet_cycles = 0;

   window_prime_checker board = new();

   sps_req_if req_bus();
   sps_rsp_if rsp_bus();

   segmented_prime_sieve_unit #(
      .BASE_LIMIT(BASE_LIMIT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Accepted requests feed the predictor; accepted responses are checked.
   always @(posedge clock) begin
      if (req_bus.valid && req_bus.ready)
         board.note_window(req_bus.window_start, req_bus.window_count);
      if (rsp_bus.valid && rsp_bus.ready)
         board.check_flags(rsp_bus.prime_flags, rsp_bus.range_error);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response side: random back-pressure, plus a long hold-off on demand.
   initial begin
      bit hold_done;
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      hold_done     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic send_request(input logic [START_W-1:0] start, input logic [COUNT_W-1:0] count);
      while (!calm_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.window_start <= start;
      req_bus.window_count <= count;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (board.outstanding() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] count;
      int                 pick;
      reset                = 1'b1;
      calm_stretch         = 1'b0;
      hold_pending         = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.window_start = '0;
      req_bus.window_count = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(START_W'(DIR_START[i]), COUNT_W'(DIR_COUNT[i]));
      req_bus.valid <= 1'b0;
      wait_drained();

      // long response hold-off while small requests keep coming
      hold_pending = 1'b1;
      for (int i = 0; i < 12; i++)
         send_request(START_W'($urandom_range(1023)), COUNT_W'($urandom_range(64, 1)));

      for (int i = 0; i < RANDOM_WINDOWS; i++) begin
         calm_stretch = (i >= 800 && i < 1100);
         if (i == 1300) begin
            req_bus.valid <= 1'b0;
            wait_drained();
         end
         pick = $urandom_range(99);
         if (pick < 63)
            start = START_W'($urandom_range(1023));
         else if (pick < 88)
            start = START_W'($urandom_range(16383));
         else if (pick < 96)
            start = START_W'($urandom_range(2 ** START_W - 1));
         else
            start = START_W'(MAX_VALUE - int'($urandom_range(160, 1)));
         pick = $urandom_range(99);
         if (pick < 4)
            count = '0;
         else if (pick < 10)
            count = COUNT_W'($urandom_range(2 ** COUNT_W - 1, WINDOW_SIZE + 1));
         else if (pick < 20)
            count = COUNT_W'(WINDOW_SIZE);
         else
            count = COUNT_W'($urandom_range(WINDOW_SIZE, 1));
         send_request(start, count);
      end
      calm_stretch = 1'b0;
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failure_count == 0 && board.outstanding() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
